[rtl/core/cwb_pkg.sv]
// ============================================================================
// Contention window backoff package
// Shared types and constants for the contention window backoff unit.
// ============================================================================
package cwb_pkg;

    localparam int WIN_W   = 16;
    localparam int MODE_W  = 2;
    localparam int OP_W    = 2;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    localparam logic [OP_W-1:0] OP_DRAW   = 2'd0;
    localparam logic [OP_W-1:0] OP_SHRINK = 2'd1;
    localparam logic [OP_W-1:0] OP_GROW   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_MILD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONST  = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_WMIN = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_WMAX = 2'd2;

    localparam logic [WIN_W-1:0] WIN_RESET = 16'd100;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV1 = 4'b0010,
        ST_DIV2 = 4'b0100,
        ST_PUT  = 4'b1000
    } state_t;

endpackage

[rtl/core/cwb_div.sv]
// ============================================================================
// Bit-serial divider
// Restoring division that shifts in one quotient bit per cycle.
// ============================================================================
module cwb_div #(
    parameter int W = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W:0]   divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W+1:0]  shifted;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = (W+1)'(shifted - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = shifted[W:0];
            end
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/contention_window_backoff_unit.sv]
// ============================================================================
// Contention window backoff unit
// Keeps a bounded contention window and draws backoff slot counts from it.
// ============================================================================
// Window updates (shrink, grow, unused opcode) pass from acceptance through
// ST_PUT to the result register. A draw takes two back-to-back divisions on
// one bit-serial divider that produces one quotient bit per cycle while busy.
// One item is in work at a time; the next item is accepted as soon as the
// finished result sits in the output register.
module contention_window_backoff_unit #(
    parameter int RANDOM_BITS = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [cwb_pkg::OP_W-1:0]   opcode,
    input  logic [30:0]            random_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [cwb_pkg::WIN_W-1:0]  backoff_slots,
    output logic [cwb_pkg::WIN_W-1:0]  window_now,
    input  logic                   cfg_we,
    input  logic [cwb_pkg::CIDX_W-1:0] cfg_index,
    input  logic [cwb_pkg::CFG_W-1:0]  cfg_data
);

    import cwb_pkg::*;

    localparam int RB = RANDOM_BITS;
    localparam int DW = (RB > WIN_W + 1) ? RB : WIN_W + 1;
    localparam logic [DW-1:0] RMAX = DW'((64'd1 << RB) - 64'd1);

    state_t             state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [WIN_W-1:0]   wmin_reg, wmin_next;
    logic [WIN_W-1:0]   wmax_reg, wmax_next;
    logic [WIN_W-1:0]   win_reg, win_next;
    logic [RB-1:0]      rnd_reg, rnd_next;
    logic               draw_reg, draw_next;
    logic               oval_reg, oval_next;
    logic [WIN_W-1:0]   slots_reg, slots_next;
    logic [WIN_W-1:0]   wnow_reg, wnow_next;

    logic               accept;
    logic               out_free;
    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic [DW:0]        div_divisor;
    logic               div_done;
    logic [DW-1:0]      div_quotient;
    logic [WIN_W:0]     grow_val;
    logic [WIN_W-1:0]   shrink_val;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !oval_reg || !out_stall;

    assign grow_val   = (mode_reg == MODE_MILD) ? {win_reg, 1'b0}
                                                : {1'b0, win_reg} + (WIN_W+1)'(1);
    assign shrink_val = win_reg - WIN_W'(1);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = RMAX;
        div_divisor  = (DW+1)'(win_reg) + (DW+1)'(1);
        if (state_reg == ST_DIV1)
        begin
            div_start    = div_done;
            div_dividend = DW'(rnd_reg);
            div_divisor  = {1'b0, div_quotient} + (DW+1)'(1);
        end
        else if (accept && opcode == OP_DRAW)
        begin
            div_start = 1'b1;
        end
    end

    cwb_div #(
        .W(DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        wmin_next  = wmin_reg;
        wmax_next  = wmax_reg;
        win_next   = win_reg;
        rnd_next   = rnd_reg;
        draw_next  = draw_reg;
        oval_next  = oval_reg && out_stall;
        slots_next = slots_reg;
        wnow_next  = wnow_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:
                begin
                    mode_next = cfg_data[MODE_W-1:0];
                    win_next  = wmin_reg;
                end
                CFG_WMIN:
                begin
                    wmin_next = cfg_data;
                    win_next  = cfg_data;
                end
                CFG_WMAX:
                begin
                    wmax_next = cfg_data;
                    win_next  = wmin_reg;
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rnd_next  = RB'(random_value);
                    draw_next = (opcode == OP_DRAW);
                    if (opcode == OP_DRAW)
                    begin
                        state_next = ST_DIV1;
                    end
                    else
                    begin
                        state_next = ST_PUT;
                        if (opcode == OP_SHRINK
                            && (mode_reg == MODE_MILD || mode_reg == MODE_LINEAR)
                            && win_reg != '0 && shrink_val >= wmin_reg)
                        begin
                            win_next = shrink_val;
                        end
                        else if (opcode == OP_GROW
                                 && (mode_reg == MODE_MILD || mode_reg == MODE_LINEAR)
                                 && grow_val <= {1'b0, wmax_reg})
                        begin
                            win_next = grow_val[WIN_W-1:0];
                        end
                    end
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    slots_next = draw_reg ? div_quotient[WIN_W-1:0] : '0;
                    wnow_next  = win_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_CONST;
            wmin_reg  <= WIN_RESET;
            wmax_reg  <= WIN_RESET;
            win_reg   <= WIN_RESET;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            wmin_reg  <= wmin_next;
            wmax_reg  <= wmax_next;
            win_reg   <= win_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg   <= rnd_next;
        draw_reg  <= draw_next;
        slots_reg <= slots_next;
        wnow_reg  <= wnow_next;
    end

    assign out_valid     = oval_reg;
    assign backoff_slots = slots_reg;
    assign window_now    = wnow_reg;

endmodule

[rtl/core/cwb_checker.sv]
// ============================================================================
// Contention window backoff checker
// Port-level assertions, bound to the contention window backoff unit.
// ============================================================================
module cwb_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [cwb_pkg::WIN_W-1:0]  backoff_slots,
    input  logic [cwb_pkg::WIN_W-1:0]  window_now
);

    import cwb_pkg::*;

    // A stalled result item keeps its valid and payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(backoff_slots)
                                  && $stable(window_now))
        else $error("Stalled result item changed.");

    // A drawn slot count never exceeds the window it was drawn from.
    a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> backoff_slots <= window_now)
        else $error("Backoff slot count exceeds the window.");

    // Only one item is in work, so the input stalls right after an accept.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Input was not stalled after an item was accepted.");

endmodule

bind contention_window_backoff_unit cwb_checker u_cwb_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// Contention window backoff unit testbench
// Checks typed rows against their table values and all other results
// against a predictor of the window and of the draw. A table of directed
// items and register writes covers the bounds, the frozen modes, shrink
// from zero, grow past 16 bits and inverted bounds. Random phases follow,
// each with its own registers and one of four sender-gap/receiver-stall mixes.
// ============================================================================
module testbench;

    import cwb_pkg::*;

    localparam int RAND_BITS = 31;
    localparam longint unsigned RAND_TOP = (64'd1 << RAND_BITS) - 64'd1;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 216;
    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD = 400;
    localparam int TAIL_CYCLES = 100;

    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam logic [CIDX_W-1:0] CFG_NONE  = 2'd3;

    typedef struct packed {
        logic [WIN_W-1:0] slots;
        logic [WIN_W-1:0] window;
    } result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [1:0]       code;
        logic [30:0]      value;
        logic             typed;
        logic [WIN_W-1:0] exp_slots;
        logic [WIN_W-1:0] exp_window;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     opcode = OP_DRAW;
    logic [30:0]         random_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [WIN_W-1:0]    backoff_slots;
    logic [WIN_W-1:0]    window_now;
    logic                cfg_we = 1'b0;
    logic [CIDX_W-1:0]   cfg_index = CFG_MODE;
    logic [CFG_W-1:0]    cfg_data = '0;

    logic [MODE_W-1:0]   cur_mode = MODE_CONST;
    logic [WIN_W-1:0]    cur_wmin = WIN_RESET;
    logic [WIN_W-1:0]    cur_wmax = WIN_RESET;
    logic [WIN_W-1:0]    cur_window = WIN_RESET;

    result_t             expected_q[$];
    result_t             got_res;
    result_t             want_res;
    int                  fails = 0;
    int                  quiet_cycles = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  hold_left = 0;
    logic                long_hold_req = 1'b0;
    logic                hold_done = 1'b0;

    logic [CIDX_W-1:0]   reg_order [3] = '{CFG_MODE, CFG_WMIN, CFG_WMAX};

    row_t dir_rows [38] = '{
        '{ROW_ITEM, OP_DRAW,   31'h0,              1'b1, 16'd0,      16'd100},
        '{ROW_ITEM, OP_DRAW,   31'h7FFFFFFF,       1'b1, 16'd100,    16'd100},
        '{ROW_ITEM, OP_SHRINK, 31'h7FFFFFFF,       1'b1, 16'd0,      16'd100},
        '{ROW_ITEM, OP_GROW,   31'h0,              1'b1, 16'd0,      16'd100},
        '{ROW_ITEM, OP_UNUSED, 31'h7FFFFFFF,       1'b1, 16'd0,      16'd100},
        '{ROW_CFG,  CFG_WMAX,  31'hFFFF,           1'b0, 16'd0,      16'd0},
        '{ROW_CFG,  CFG_MODE,  31'(MODE_LINEAR),   1'b0, 16'd0,      16'd0},
        '{ROW_ITEM, OP_GROW,   31'h0,              1'b1, 16'd0,      16'd101},
        '{ROW_CFG,  CFG_NONE,  31'hFFFF,           1'b0, 16'd0,      16'd0},
        '{ROW_ITEM, OP_UNUSED, 31'h0,              1'b1, 16'd0,      16'd101},
        '{ROW_ITEM, OP_SHRINK, 31'h0,              1'b1, 16'd0,      16'd100},
        '{ROW_ITEM, OP_SHRINK, 31'h0,              1'b1, 16'd0,      16'd100},
        '{ROW_CFG,  CFG_MODE,  31'(MODE_MILD),     1'b0, 16'd0,      16'd0},
        '{ROW_ITEM, OP_GROW,   31'h0,              1'b1, 16'd0,      16'd200},
        '{ROW_ITEM, OP_DRAW,   31'h5A5A5A5A,       1'b0, 16'd0,      16'd0},
        '{ROW_CFG,  CFG_WMIN,  31'h0,              1'b0, 16'd0,      16'd0},
        '{ROW_ITEM, OP_SHRINK, 31'h0,              1'b1, 16'd0,      16'd0},
        '{ROW_ITEM, OP_GROW,   31'h0,              1'b1, 16'd0,      16'd0},
        '{ROW_ITEM, OP_DRAW,   31'h7FFFFFFF,       1'b1, 16'd0,      16'd0},
        '{ROW_CFG,  CFG_WMIN,  31'h8000,           1'b0, 16'd0,      16'd0},
        '{ROW_ITEM, OP_GROW,   31'h0,              1'b1, 16'd0,      16'h8000},
        '{ROW_ITEM, OP_DRAW,   31'h7FFFFFFF,       1'b0, 16'd0,      16'd0},
        '{ROW_CFG,  CFG_WMIN,  31'hFFFF,           1'b0, 16'd0,      16'd0},
        '{ROW_ITEM, OP_DRAW,   31'h7FFFFFFF,       1'b1, 16'hFFFF,   16'hFFFF},
        '{ROW_ITEM, OP_GROW,   31'h0,              1'b1, 16'd0,      16'hFFFF},
        '{ROW_CFG,  CFG_MODE,  31'(MODE_LINEAR),   1'b0, 16'd0,      16'd0},
        '{ROW_ITEM, OP_GROW,   31'h0,              1'b1, 16'd0,      16'hFFFF},
        '{ROW_CFG,  CFG_MODE,  31'(MODE_NONE),     1'b0, 16'd0,      16'd0},
        '{ROW_ITEM, OP_SHRINK, 31'h0,              1'b1, 16'd0,      16'hFFFF},
        '{ROW_ITEM, OP_GROW,   31'h0,              1'b1, 16'd0,      16'hFFFF},
        '{ROW_CFG,  CFG_MODE,  31'(MODE_LINEAR),   1'b0, 16'd0,      16'd0},
        '{ROW_CFG,  CFG_WMIN,  31'd10,             1'b0, 16'd0,      16'd0},
        '{ROW_CFG,  CFG_WMAX,  31'd5,              1'b0, 16'd0,      16'd0},
        '{ROW_ITEM, OP_GROW,   31'h0,              1'b1, 16'd0,      16'd10},
        '{ROW_ITEM, OP_SHRINK, 31'h0,              1'b1, 16'd0,      16'd10},
        '{ROW_ITEM, OP_DRAW,   31'h12345678,       1'b0, 16'd0,      16'd0},
        '{ROW_CFG,  CFG_WMAX,  31'h0,              1'b0, 16'd0,      16'd0},
        '{ROW_ITEM, OP_GROW,   31'h0,              1'b1, 16'd0,      16'd10}
    };

    contention_window_backoff_unit #(
        .RANDOM_BITS (RAND_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .random_value  (random_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .backoff_slots (backoff_slots),
        .window_now    (window_now),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic result_t predict_item(input logic [OP_W-1:0] op, input logic [30:0] rv);
        result_t         res;
        logic [16:0]     grown;
        longint unsigned step;
        res.slots = '0;
        case (op)
            OP_DRAW:
            begin
                step = RAND_TOP / (64'(cur_window) + 64'd1) + 64'd1;
                res.slots = 16'((64'(rv) & RAND_TOP) / step);
            end
            OP_SHRINK:
            begin
                if ((cur_mode == MODE_MILD || cur_mode == MODE_LINEAR) && cur_window != '0
                    && cur_window - 16'd1 >= cur_wmin)
                    cur_window = cur_window - 16'd1;
            end
            OP_GROW:
            begin
                if (cur_mode == MODE_MILD || cur_mode == MODE_LINEAR)
                begin
                    grown = (cur_mode == MODE_MILD) ? {cur_window, 1'b0}
                                                    : {1'b0, cur_window} + 17'd1;
                    if (grown <= {1'b0, cur_wmax})
                        cur_window = grown[15:0];
                end
            end
            default: ;
        endcase
        res.window = cur_window;
        return res;
    endfunction

    function automatic logic [30:0] pick_random();
        longint unsigned step;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 31'($urandom_range(0, 65535));
            3, 4:
            begin
                step = RAND_TOP / (64'(cur_window) + 64'd1) + 64'd1;
                return 31'(step * 64'($urandom_range(0, 32'(cur_window)))
                           - 64'($urandom_range(0, 1)));
            end
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [30:0] rv,
                             input logic typed, input result_t typed_res);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        random_value <= rv;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_item(op, rv);
        if (typed)
            predicted = typed_res;
        expected_q.push_back(predicted);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_MODE: cur_mode = val[MODE_W-1:0];
            CFG_WMIN: cur_wmin = val;
            CFG_WMAX: cur_wmax = val;
            default: ;
        endcase
        if (idx != CFG_NONE)
            cur_window = cur_wmin;
    endtask

    // Results are sampled with the values that stood before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_res = {backoff_slots, window_now};
            if (expected_q.size() == 0)
            begin
                if (fails < 10)
                    $display("unexpected result: slots %0d window %0d",
                             got_res.slots, got_res.window);
                fails++;
            end
            else
            begin
                want_res = expected_q.pop_front();
                if (got_res.slots !== want_res.slots || got_res.window !== want_res.window)
                begin
                    if (fails < 10)
                        $display("mismatch: expected slots %0d window %0d, got slots %0d window %0d",
                                 want_res.slots, want_res.window, got_res.slots, got_res.window);
                    fails++;
                end
            end
        end
        if (long_hold_req && !hold_done)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [OP_W-1:0]   op;
        logic [MODE_W-1:0] m;
        logic [CFG_W-1:0]  lo;
        logic [CFG_W-1:0]  hi;
        logic [CFG_W-1:0]  mode_val;
        logic [CIDX_W-1:0] reg_idx;
        int                sel;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].code, dir_rows[i].value[15:0]);
            else
                send_item(dir_rows[i].code, dir_rows[i].value, dir_rows[i].typed,
                          {dir_rows[i].exp_slots, dir_rows[i].exp_window});
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin m = MODE_MILD;   lo = 16'd1;     hi = 16'd1023; end
                1: begin m = MODE_LINEAR; lo = 16'd15;    hi = 16'd100;  end
                2: begin m = MODE_MILD;   lo = 16'd1;     hi = 16'hFFFF; end
                3: begin m = MODE_LINEAR; lo = 16'hFFF0;  hi = 16'hFFFF; end
                5: begin m = MODE_NONE;   lo = 16'($urandom); hi = 16'($urandom); end
                6: begin m = MODE_CONST;  lo = 16'd100;   hi = 16'd1027; end
                default:
                begin
                    m = 2'($urandom_range(0, 1));
                    lo = 16'($urandom_range(0, 40));
                    hi = 16'($urandom);
                end
            endcase
            mode_val = (16'($urandom) & 16'hFFFC) | 16'(m);
            for (int k = 0; k < 3; k++)
            begin
                reg_idx = reg_order[(k + ph) % 3];
                write_reg(reg_idx, (reg_idx == CFG_MODE) ? mode_val :
                                   (reg_idx == CFG_WMIN) ? lo : hi);
            end

            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            if (ph == 4)
                long_hold_req = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                sel = $urandom_range(0, 99);
                op = (sel < 35) ? OP_DRAW : (sel < 65) ? OP_SHRINK :
                     (sel < 95) ? OP_GROW : OP_UNUSED;
                send_item(op, pick_random(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
